// ----- rtl/hgpp_pkg.sv -----
// Shared types, constants and neighbor tables for the hex grid point picker.
package hgpp_pkg;

    // Default widths
    localparam int COORD_BITS_DEF = 24;
    localparam int CELL_BITS_DEF  = 16;

    // Cell size after reset: 1.0 in Q6.18
    localparam int CELL_SIZE_RESET = 262144;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CELL_WIDTH  = 2'd0,
        CFG_CELL_HEIGHT = 2'd1,
        CFG_CAMERA_COL  = 2'd2,
        CFG_CAMERA_ROW  = 2'd3
    } t_cfg_idx;

    // Candidate cells: the estimate, then NE, E, SE, SW, W, NW
    localparam int NUM_CAND = 7;
    localparam int NUM_ROWS = 3;
    localparam int SEL_BITS = 3;

    // Column step for even and odd rows
    localparam logic signed [1:0] CAND_DQ_EVEN [NUM_CAND] =
        '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1};
    localparam logic signed [1:0] CAND_DQ_ODD [NUM_CAND] =
        '{2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, 2'sd0};
    // Row slot of each candidate: 0 = row above, 1 = same row, 2 = row below
    localparam logic [1:0] CAND_ROW [NUM_CAND] =
        '{2'd1, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0};
    localparam logic [1:0] ROW_SAME = 2'd1;

    // Side flags of one division
    typedef struct packed {
        logic neg;   // dividend was negative
        logic rnz;   // remainder nonzero
    } t_div_flags;

endpackage

// ----- rtl/hgpp_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, magnitude of a signed dividend.
module hgpp_div #(
    parameter int COORD_BITS = hgpp_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_num,
    input  logic        [COORD_BITS-2:0] i_den,
    output logic                         o_valid,
    output logic        [COORD_BITS-1:0] o_quo,
    output hgpp_pkg::t_div_flags         o_flags,
    output logic signed [COORD_BITS-1:0] o_num
);

    localparam int CB = COORD_BITS;

    logic [CB-1:0] mag;

    // stage inputs
    logic                 s_vld [CB];
    logic        [CB-1:0] s_rem [CB];
    logic        [CB-1:0] s_quo [CB];
    logic        [CB-1:0] s_dvd [CB];
    logic                 s_neg [CB];
    logic signed [CB-1:0] s_num [CB];
    logic        [CB-1:0] s_try [CB];
    logic                 s_ge  [CB];

    // next values and stage registers
    logic        [CB-1:0] n_rem [CB];
    logic        [CB-1:0] n_quo [CB];
    logic        [CB-1:0] n_dvd [CB];
    logic                 r_vld [CB];
    logic        [CB-1:0] r_rem [CB];
    logic        [CB-1:0] r_quo [CB];
    logic        [CB-1:0] r_dvd [CB];
    logic                 r_neg [CB];
    logic signed [CB-1:0] r_num [CB];

    // magnitude of the dividend; the most negative value maps to 2^(CB-1)
    assign mag = i_num[CB-1] ? (~i_num + CB'(1)) : i_num;

    // stage input chaining
    for (genvar k = 0; k < CB; k++) begin : g_chain
        if (k == 0) begin : g_first
            assign s_vld[k] = i_valid;
            assign s_rem[k] = '0;
            assign s_quo[k] = '0;
            assign s_dvd[k] = mag;
            assign s_neg[k] = i_num[CB-1];
            assign s_num[k] = i_num;
        end else begin : g_next
            assign s_vld[k] = r_vld[k-1];
            assign s_rem[k] = r_rem[k-1];
            assign s_quo[k] = r_quo[k-1];
            assign s_dvd[k] = r_dvd[k-1];
            assign s_neg[k] = r_neg[k-1];
            assign s_num[k] = r_num[k-1];
        end
    end

    // one shift, compare and subtract per stage
    always_comb begin
        for (int k = 0; k < CB; k++) begin
            s_try[k] = {s_rem[k][CB-2:0], s_dvd[k][CB-1]};
            s_ge[k]  = (s_try[k] >= {1'b0, i_den});
            n_rem[k] = s_ge[k] ? (s_try[k] - {1'b0, i_den}) : s_try[k];
            n_quo[k] = {s_quo[k][CB-2:0], s_ge[k]};
            n_dvd[k] = {s_dvd[k][CB-2:0], 1'b0};
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CB; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < CB; k++) r_vld[k] <= s_vld[k];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < CB; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_dvd[k] <= n_dvd[k];
                r_neg[k] <= s_neg[k];
                r_num[k] <= s_num[k];
            end
        end
    end

    assign o_valid     = r_vld[CB-1];
    assign o_quo       = r_quo[CB-1];
    assign o_flags.neg = r_neg[CB-1];
    assign o_flags.rnz = |r_rem[CB-1];
    assign o_num       = r_num[CB-1];

endmodule

// ----- rtl/hgpp_cand.sv -----
// Cell estimate, the seven candidate cells and the point offset from each candidate center.
module hgpp_cand #(
    parameter int COORD_BITS = hgpp_pkg::COORD_BITS_DEF,
    parameter int CELL_BITS  = hgpp_pkg::CELL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic        [COORD_BITS-1:0] i_quo_x,
    input  hgpp_pkg::t_div_flags         i_flags_x,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic        [COORD_BITS-1:0] i_quo_y,
    input  hgpp_pkg::t_div_flags         i_flags_y,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic        [COORD_BITS-2:0] i_cell_w,
    input  logic        [COORD_BITS-2:0] i_cell_h,
    input  logic        [CELL_BITS-1:0]  i_cam_col,
    input  logic        [CELL_BITS-1:0]  i_cam_row,
    output logic                         o_valid,
    output logic signed [COORD_BITS+1:0] o_lx  [hgpp_pkg::NUM_CAND],
    output logic signed [COORD_BITS+1:0] o_ly  [hgpp_pkg::NUM_ROWS],
    output logic        [CELL_BITS-1:0]  o_col [hgpp_pkg::NUM_CAND],
    output logic        [CELL_BITS-1:0]  o_row [hgpp_pkg::NUM_ROWS]
);

    localparam int CB = COORD_BITS;
    localparam int NB = CELL_BITS;
    localparam int NC = hgpp_pkg::NUM_CAND;
    localparam int NR = hgpp_pkg::NUM_ROWS;
    localparam int EW = ((CB > NB) ? CB : NB) + 2;  // estimate arithmetic
    localparam int MW = NB + 1 + CB;                // camera-relative product
    localparam int LW = MW + 4;                     // full offset
    localparam int SW = CB + 2;                     // clamped offset

    localparam logic signed [EW-1:0] E_HI = {{(EW-NB+1){1'b0}}, {(NB-1){1'b1}}};
    localparam logic signed [EW-1:0] E_LO = ~E_HI;
    localparam logic signed [LW-1:0] S_HI = {{(LW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [LW-1:0] S_LO = ~S_HI;

    // trunc(num/den + cam) toward zero, saturated to the cell width
    function automatic logic [NB-1:0] est_cell(input logic [CB-1:0] quo,
                                               input hgpp_pkg::t_div_flags fl,
                                               input logic [NB-1:0] cam);
        logic signed [EW-1:0] qe;
        logic signed [EW-1:0] e;
        logic        [NB-1:0] res;
        qe = {{(EW-CB){1'b0}}, quo};
        e  = fl.neg ? (-qe - {{(EW-1){1'b0}}, fl.rnz}) : qe;
        e  = e + {{(EW-NB){cam[NB-1]}}, cam};
        if (e[EW-1] && fl.rnz) e = e + EW'(1);
        if (e > E_HI)      res = E_HI[NB-1:0];
        else if (e < E_LO) res = E_LO[NB-1:0];
        else               res = e[NB-1:0];
        return res;
    endfunction

    // clamp an offset; values past the clamp lie outside every hexagon test band
    function automatic logic signed [SW-1:0] sat_off(input logic signed [LW-1:0] v);
        logic signed [SW-1:0] res;
        if (v > S_HI)      res = S_HI[SW-1:0];
        else if (v < S_LO) res = S_LO[SW-1:0];
        else               res = v[SW-1:0];
        return res;
    endfunction

    // ---- stage E: cell estimate
    logic                 r_e_vld;
    logic        [NB-1:0] r_eq;
    logic        [NB-1:0] r_er;
    logic signed [CB-1:0] r_e_px;
    logic signed [CB-1:0] r_e_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_vld <= 1'b0;
        else if (i_en) r_e_vld <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_eq   <= est_cell(i_quo_x, i_flags_x, i_cam_col);
            r_er   <= est_cell(i_quo_y, i_flags_y, i_cam_row);
            r_e_px <= i_px;
            r_e_py <= i_py;
        end
    end

    // ---- stage M1: candidate cells and camera-relative products
    logic        [NB-1:0] n_col [NC];
    logic        [NB-1:0] n_row [NR];
    logic signed [NB:0]   s_dq  [NC];
    logic signed [NB:0]   s_dr  [NR];
    logic signed [MW-1:0] n_mx  [NC];
    logic signed [MW-1:0] n_my  [NR];
    logic        [1:0]    s_off [NC];

    always_comb begin
        n_row[0] = r_er - NB'(1);
        n_row[1] = r_er;
        n_row[2] = r_er + NB'(1);
        for (int i = 0; i < NC; i++) begin
            s_off[i] = r_er[0] ? hgpp_pkg::CAND_DQ_ODD[i] : hgpp_pkg::CAND_DQ_EVEN[i];
            n_col[i] = r_eq + {{(NB-2){s_off[i][1]}}, s_off[i]};
            s_dq[i]  = {i_cam_col[NB-1], i_cam_col} - {n_col[i][NB-1], n_col[i]};
            n_mx[i]  = s_dq[i] * $signed({1'b0, i_cell_w});
        end
        for (int j = 0; j < NR; j++) begin
            s_dr[j] = {i_cam_row[NB-1], i_cam_row} - {n_row[j][NB-1], n_row[j]};
            n_my[j] = s_dr[j] * $signed({1'b0, i_cell_h});
        end
    end

    logic                 r_m_vld;
    logic signed [MW-1:0] r_mx  [NC];
    logic signed [MW-1:0] r_my  [NR];
    logic        [NB-1:0] r_m_col [NC];
    logic        [NB-1:0] r_m_row [NR];
    logic                 r_m_odd;
    logic signed [CB-1:0] r_m_px;
    logic signed [CB-1:0] r_m_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_vld <= 1'b0;
        else if (i_en) r_m_vld <= r_e_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx    <= n_mx;
            r_my    <= n_my;
            r_m_col <= n_col;
            r_m_row <= n_row;
            r_m_odd <= r_er[0];
            r_m_px  <= r_e_px;
            r_m_py  <= r_e_py;
        end
    end

    // ---- stage M2: offset of the point from each candidate center, x4 units
    logic signed [LW-1:0] s_lx [NC];
    logic signed [LW-1:0] s_ly [NR];
    logic                 s_odd [NC];

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            s_odd[i] = (hgpp_pkg::CAND_ROW[i] == hgpp_pkg::ROW_SAME) ? r_m_odd : !r_m_odd;
            s_lx[i]  = ({{(LW-CB){r_m_px[CB-1]}}, r_m_px}
                        + {{(LW-MW){r_mx[i][MW-1]}}, r_mx[i]}) <<< 2;
            // odd rows sit half a cell to the right
            if (s_odd[i]) s_lx[i] = s_lx[i] - {{(LW-CB){1'b0}}, i_cell_w, 1'b0};
        end
        for (int j = 0; j < NR; j++) begin
            s_ly[j] = ({{(LW-CB){r_m_py[CB-1]}}, r_m_py}
                       + {{(LW-MW){r_my[j][MW-1]}}, r_my[j]}) <<< 2;
        end
    end

    logic r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else if (i_en) r_o_vld <= r_m_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NC; i++) o_lx[i] <= sat_off(s_lx[i]);
            for (int j = 0; j < NR; j++) o_ly[j] <= sat_off(s_ly[j]);
            o_col <= r_m_col;
            o_row <= r_m_row;
        end
    end

    assign o_valid = r_o_vld;

endmodule

// ----- rtl/hgpp_test.sv -----
// Crossing-count point-in-hexagon test of the seven candidates and first-hit select.
module hgpp_test #(
    parameter int COORD_BITS = hgpp_pkg::COORD_BITS_DEF,
    parameter int CELL_BITS  = hgpp_pkg::CELL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS+1:0] i_lx  [hgpp_pkg::NUM_CAND],
    input  logic signed [COORD_BITS+1:0] i_ly  [hgpp_pkg::NUM_ROWS],
    input  logic        [CELL_BITS-1:0]  i_col [hgpp_pkg::NUM_CAND],
    input  logic        [CELL_BITS-1:0]  i_row [hgpp_pkg::NUM_ROWS],
    input  logic        [COORD_BITS-2:0] i_cell_w,
    input  logic        [COORD_BITS-2:0] i_cell_h,
    output logic                         o_valid,
    output logic        [CELL_BITS-1:0]  o_hit_col,
    output logic        [CELL_BITS-1:0]  o_hit_row,
    output logic                         o_found
);

    localparam int CB = COORD_BITS;
    localparam int NB = CELL_BITS;
    localparam int NC = hgpp_pkg::NUM_CAND;
    localparam int NR = hgpp_pkg::NUM_ROWS;
    localparam int SW = CB + 2;
    localparam int PW = SW + CB;
    localparam int RW = 2 * CB - 2;
    localparam int CW = PW + 3;

    // where lx sits against the hexagon's x corners
    typedef struct packed {
        logic lt0;    // lx < 0
        logic le0;    // lx <= 0
        logic le2w;   // lx <= 2w
        logic ltm2w;  // lx < -2w
        logic lem2w;  // lx <= -2w
    } t_x_flags;

    // which band of the hexagon ly falls in
    typedef struct packed {
        logic up;     // -2h < ly <= -h
        logic mid;    // -h  < ly <=  h
        logic low;    //  h  < ly <= 2h
    } t_y_flags;

    // ---- stage T1: edge products and band flags
    logic signed [SW-1:0] c_tw, c_ntw, c_h1, c_h2, c_nh1, c_nh2;
    t_x_flags             n_xf [NC];
    t_y_flags             n_yf [NR];
    logic signed [PW-1:0] n_p  [NC];
    logic signed [PW-1:0] n_q  [NR];

    always_comb begin
        c_tw  = $signed({2'b00, i_cell_w, 1'b0});
        c_ntw = -c_tw;
        c_h1  = $signed({3'b000, i_cell_h});
        c_h2  = $signed({2'b00, i_cell_h, 1'b0});
        c_nh1 = -c_h1;
        c_nh2 = -c_h2;
        for (int i = 0; i < NC; i++) begin
            n_xf[i].lt0   = i_lx[i][SW-1];
            n_xf[i].le0   = i_lx[i][SW-1] || (i_lx[i] == '0);
            n_xf[i].le2w  = (i_lx[i] <= c_tw);
            n_xf[i].ltm2w = (i_lx[i] < c_ntw);
            n_xf[i].lem2w = (i_lx[i] <= c_ntw);
            n_p[i]        = i_lx[i] * $signed({1'b0, i_cell_h});
        end
        for (int j = 0; j < NR; j++) begin
            n_yf[j].up  = (i_ly[j] > c_nh2) && (i_ly[j] <= c_nh1);
            n_yf[j].mid = (i_ly[j] > c_nh1) && (i_ly[j] <= c_h1);
            n_yf[j].low = (i_ly[j] > c_h1)  && (i_ly[j] <= c_h2);
            n_q[j]      = i_ly[j] * $signed({1'b0, i_cell_w});
        end
    end

    logic                 r_t_vld;
    t_x_flags             r_xf  [NC];
    t_y_flags             r_yf  [NR];
    logic signed [PW-1:0] r_p   [NC];
    logic signed [PW-1:0] r_q   [NR];
    logic        [RW-1:0] r_hw;
    logic        [NB-1:0] r_col [NC];
    logic        [NB-1:0] r_row [NR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_t_vld <= 1'b0;
        else if (i_en) r_t_vld <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xf  <= n_xf;
            r_yf  <= n_yf;
            r_p   <= n_p;
            r_q   <= n_q;
            r_hw  <= i_cell_w * i_cell_h;
            r_col <= i_col;
            r_row <= i_row;
        end
    end

    // ---- stage T2: slanted edge compares, crossing parity, first hit
    // P = lx*h, Q = ly*w, R = w*h; each slanted edge reduces to P against +-2Q + 4R
    logic signed [CW-1:0] s_p  [NC];
    logic signed [CW-1:0] s_np [NC];
    logic signed [CW-1:0] s_a  [NC];
    logic signed [CW-1:0] s_b  [NC];
    logic signed [CW-1:0] s_q2 [NC];
    logic signed [CW-1:0] s_r4;
    logic        [5:0]    s_cross [NC];
    logic        [NC-1:0] s_hit;
    t_y_flags             s_yf [NC];
    logic [hgpp_pkg::SEL_BITS-1:0] s_sel;

    always_comb begin
        s_r4 = {{(CW-RW-2){1'b0}}, r_hw, 2'b00};
        for (int i = 0; i < NC; i++) begin
            s_yf[i] = r_yf[hgpp_pkg::CAND_ROW[i]];
            s_q2[i] = {{(CW-PW-1){r_q[hgpp_pkg::CAND_ROW[i]][PW-1]}},
                       r_q[hgpp_pkg::CAND_ROW[i]], 1'b0};
            s_p[i]  = {{(CW-PW){r_p[i][PW-1]}}, r_p[i]};
            s_np[i] = -s_p[i];
            s_a[i]  = s_q2[i] + s_r4;
            s_b[i]  = s_r4 - s_q2[i];
            // top-right edge
            s_cross[i][0] = s_yf[i].up && r_xf[i].le2w && (r_xf[i].lt0 || (s_p[i] <= s_a[i]));
            // right vertical edge
            s_cross[i][1] = s_yf[i].mid && r_xf[i].le2w;
            // bottom-right edge
            s_cross[i][2] = s_yf[i].low && r_xf[i].le2w && (r_xf[i].lt0 || (s_p[i] <= s_b[i]));
            // bottom-left edge
            s_cross[i][3] = s_yf[i].low && r_xf[i].le0
                            && (r_xf[i].ltm2w || (s_np[i] >= s_b[i]));
            // left vertical edge
            s_cross[i][4] = s_yf[i].mid && r_xf[i].lem2w;
            // top-left edge
            s_cross[i][5] = s_yf[i].up && r_xf[i].le0
                            && (r_xf[i].ltm2w || (s_np[i] >= s_a[i]));
            s_hit[i] = ^s_cross[i];
        end
        // lowest index wins; the estimate is the fallback
        s_sel = '0;
        for (int i = NC - 1; i >= 0; i--) begin
            if (s_hit[i]) s_sel = hgpp_pkg::SEL_BITS'(i);
        end
    end

    logic          r_o_vld;
    logic [NB-1:0] r_hit_col;
    logic [NB-1:0] r_hit_row;
    logic          r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else if (i_en) r_o_vld <= r_t_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit_col <= r_col[s_sel];
            r_hit_row <= r_row[hgpp_pkg::CAND_ROW[s_sel]];
            r_found   <= |s_hit;
        end
    end

    assign o_valid   = r_o_vld;
    assign o_hit_col = r_hit_col;
    assign o_hit_row = r_hit_row;
    assign o_found   = r_found;

endmodule

// ----- rtl/hex_grid_point_pick_top.sv -----
// Top level of the hex grid point picker: configuration registers and pipeline.
//
// Maps a signed fixed-point screen point to a cell of an odd-row offset hex grid.
// One point is accepted every clock while the output is not stalled. Each point
// first passes the two dividers (point / cell size), which resolve one quotient
// bit per stage; after them come the estimate stage, two stages forming offsets
// from the seven candidate centers, and two stages for the hexagon test and the
// output register. When a result is held by the output stall the whole pipeline
// holds and the input stall is raised in the same cycle. Write configuration only
// while no request is in flight.
module hex_grid_point_pick_top #(
    parameter int COORD_BITS = hgpp_pkg::COORD_BITS_DEF,
    parameter int CELL_BITS  = hgpp_pkg::CELL_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration write port
    input  logic                                    i_cfg_we,
    input  logic [hgpp_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [((COORD_BITS-1 > CELL_BITS) ? COORD_BITS-1 : CELL_BITS)-1:0] i_cfg_wdata,
    // point requests
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [COORD_BITS-1:0]            i_point_x,
    input  logic signed [COORD_BITS-1:0]            i_point_y,
    // results
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [CELL_BITS-1:0]             o_hit_col,
    output logic signed [CELL_BITS-1:0]             o_hit_row,
    output logic                                    o_found
);

    localparam int CB = COORD_BITS;
    localparam int NB = CELL_BITS;
    localparam int NC = hgpp_pkg::NUM_CAND;
    localparam int NR = hgpp_pkg::NUM_ROWS;

    // ---- configuration registers
    logic [CB-2:0] r_cell_width;
    logic [CB-2:0] r_cell_height;
    logic [NB-1:0] r_camera_col;
    logic [NB-1:0] r_camera_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width  <= (CB-1)'(hgpp_pkg::CELL_SIZE_RESET);
            r_cell_height <= (CB-1)'(hgpp_pkg::CELL_SIZE_RESET);
            r_camera_col  <= '0;
            r_camera_row  <= '0;
        end else if (i_cfg_we) begin
            unique case (hgpp_pkg::t_cfg_idx'(i_cfg_idx))
                hgpp_pkg::CFG_CELL_WIDTH:  r_cell_width  <= i_cfg_wdata[CB-2:0];
                hgpp_pkg::CFG_CELL_HEIGHT: r_cell_height <= i_cfg_wdata[CB-2:0];
                hgpp_pkg::CFG_CAMERA_COL:  r_camera_col  <= i_cfg_wdata[NB-1:0];
                hgpp_pkg::CFG_CAMERA_ROW:  r_camera_row  <= i_cfg_wdata[NB-1:0];
            endcase
        end
    end

    // a zero size counts as one LSB
    logic [CB-2:0] cell_w;
    logic [CB-2:0] cell_h;
    assign cell_w = (r_cell_width  == '0) ? (CB-1)'(1) : r_cell_width;
    assign cell_h = (r_cell_height == '0) ? (CB-1)'(1) : r_cell_height;

    // ---- pipeline advance: hold everything while a result waits
    logic adv;
    assign o_in_stall = o_out_valid && i_out_stall;
    assign adv        = !o_in_stall;

    // ---- dividers
    logic                  dx_valid, dy_valid;
    logic        [CB-1:0]  dx_quo, dy_quo;
    hgpp_pkg::t_div_flags  dx_flags, dy_flags;
    logic signed [CB-1:0]  dx_num, dy_num;

    hgpp_div #(.COORD_BITS(CB)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_num   (i_point_x),
        .i_den   (cell_w),
        .o_valid (dx_valid),
        .o_quo   (dx_quo),
        .o_flags (dx_flags),
        .o_num   (dx_num)
    );

    hgpp_div #(.COORD_BITS(CB)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_num   (i_point_y),
        .i_den   (cell_h),
        .o_valid (dy_valid),
        .o_quo   (dy_quo),
        .o_flags (dy_flags),
        .o_num   (dy_num)
    );

    // ---- candidates
    logic                 c_valid;
    logic signed [CB+1:0] c_lx  [NC];
    logic signed [CB+1:0] c_ly  [NR];
    logic        [NB-1:0] c_col [NC];
    logic        [NB-1:0] c_row [NR];

    hgpp_cand #(.COORD_BITS(CB), .CELL_BITS(NB)) u_cand (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (dx_valid && dy_valid),
        .i_quo_x   (dx_quo),
        .i_flags_x (dx_flags),
        .i_px      (dx_num),
        .i_quo_y   (dy_quo),
        .i_flags_y (dy_flags),
        .i_py      (dy_num),
        .i_cell_w  (cell_w),
        .i_cell_h  (cell_h),
        .i_cam_col (r_camera_col),
        .i_cam_row (r_camera_row),
        .o_valid   (c_valid),
        .o_lx      (c_lx),
        .o_ly      (c_ly),
        .o_col     (c_col),
        .o_row     (c_row)
    );

    // ---- hexagon test and output register
    logic [NB-1:0] t_hit_col_w;
    logic [NB-1:0] t_hit_row_w;

    hgpp_test #(.COORD_BITS(CB), .CELL_BITS(NB)) u_test (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (c_valid),
        .i_lx      (c_lx),
        .i_ly      (c_ly),
        .i_col     (c_col),
        .i_row     (c_row),
        .i_cell_w  (cell_w),
        .i_cell_h  (cell_h),
        .o_valid   (o_out_valid),
        .o_hit_col (t_hit_col_w),
        .o_hit_row (t_hit_row_w),
        .o_found   (o_found)
    );

    assign o_hit_col = $signed(t_hit_col_w);
    assign o_hit_row = $signed(t_hit_row_w);

endmodule

// ----- rtl/hgpp_chk.sv -----
// Port-level checker for the hex grid point picker, bound to the top level.
module hgpp_chk #(
    parameter int CELL_BITS = hgpp_pkg::CELL_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic signed [CELL_BITS-1:0] o_hit_col,
    input logic signed [CELL_BITS-1:0] o_hit_row,
    input logic                        o_found
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_hit_col) && $stable(o_hit_row) && $stable(o_found))
        else $error("result changed while stalled");

    // the input side stalls exactly when a finished result is held
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall not tied to held result");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind hex_grid_point_pick_top hgpp_chk #(.CELL_BITS(CELL_BITS)) u_hgpp_chk (.*);
